// ----- sv/cmdlex_pkg.sv -----
// cmdlex_pkg: shared types, token class codes, keyword text and character
// helpers for the command lexer. No dependencies.
package cmdlex_pkg;

   localparam int KEYWORD_CHARS = 6;
   // word length saturates at KEYWORD_CHARS + 1
   localparam int WORD_LEN_WIDTH = $clog2(KEYWORD_CHARS + 2);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_WIDTH = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_WIDTH = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   localparam logic [23:0] KW_GET    = "get";
   localparam logic [23:0] KW_SET    = "set";
   localparam logic [47:0] KW_UPDATE = "update";
   localparam logic [47:0] KW_DELETE = "delete";

   localparam logic [2:0] CLS_END     = 3'd0;
   localparam logic [2:0] CLS_KEYWORD = 3'd1;
   localparam logic [2:0] CLS_IDENT   = 3'd2;
   localparam logic [2:0] CLS_LITERAL = 3'd3;
   localparam logic [2:0] CLS_INVALID = 3'd4;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_WORD = 3'b010,
      MODE_LIT  = 3'b100
   } scan_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] value_char;
      logic [2:0] token_class;
      logic       last_of_run;
   } rsp_entry_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic rsp_entry_type mk_char(input logic [7:0] c);
      rsp_entry_type e;
      e = '0;
      e.kind = KIND_CHAR;
      e.value_char = c;
      return e;
   endfunction

   function automatic rsp_entry_type mk_close(input logic [2:0] cls);
      rsp_entry_type e;
      e = '0;
      e.kind = KIND_CLOSE;
      e.token_class = cls;
      return e;
   endfunction

endpackage

// ----- sv/command_lexer.sv -----
// command_lexer: one-character-per-cycle command line lexer (top level).
// Depends on cmdlex_pkg.
//
// Usage:
//   Request channel (req_*): one ASCII character per request, or an
//   end-of-line marker (req_end_of_line = 1, character ignored).
//   Response channel (rsp_*): zero, one or two responses per request. A
//   response is either a lowercased value character of the current token
//   (rsp_kind = 0) or a token close with its class (rsp_kind = 1: end,
//   keyword, identifier, literal, invalid). rsp_last_of_run marks the final
//   response of each request.
//   Queueing: the lexer state updates in the same cycle a request is taken,
//   and its responses go into a 4-entry response queue, where they can be
//   taken from the cycle after acceptance, behind any older responses.
//   Throughput: one request per cycle as long as the queue has room for two
//   responses; the response port drains one response per cycle while
//   rsp_ready is high, so requests that give two responses (such as a token
//   close plus a new character) take two response transfers to drain.
//   Reset: lexer returns to idle between tokens, word buffer cleared,
//   response queue emptied.
//   Stall: when rsp_ready is low the head response holds; req_ready drops
//   once fewer than two queue slots remain free.
module command_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_value_char,
   output logic [2:0] rsp_token_class,
   output logic       rsp_last_of_run
);
   import cmdlex_pkg::*;

   // lexer state
   scan_mode_type                 mode_ff, mode_in;
   logic [7:0]                    chars_ff [KEYWORD_CHARS];
   logic [7:0]                    chars_in [KEYWORD_CHARS];
   logic [WORD_LEN_WIDTH-1:0]     len_ff, len_in;

   // response queue
   rsp_entry_type                 queue_ff [RSP_DEPTH];
   logic [RSP_PTR_WIDTH-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_WIDTH-1:0]      count_ff;

   rsp_entry_type                 res0, res1;
   logic [1:0]                    n_res;
   logic [7:0]                    lc;
   logic                          word_kw;
   logic [2:0]                    close_cls;
   logic                          req_take, rsp_take;

   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   // room for the worst case of two responses
   assign req_ready = (count_ff <= RSP_CNT_WIDTH'(RSP_DEPTH - 2));

   assign lc = to_lower(req_char_code);

   // keyword match on whole words of three or six characters
   always_comb begin
      word_kw = 1'b0;
      if (len_ff == WORD_LEN_WIDTH'(3)) begin
         word_kw = ({chars_ff[0], chars_ff[1], chars_ff[2]} == KW_GET) ||
                   ({chars_ff[0], chars_ff[1], chars_ff[2]} == KW_SET);
      end else if (len_ff == WORD_LEN_WIDTH'(6)) begin
         word_kw = ({chars_ff[0], chars_ff[1], chars_ff[2],
                     chars_ff[3], chars_ff[4], chars_ff[5]} == KW_UPDATE) ||
                   ({chars_ff[0], chars_ff[1], chars_ff[2],
                     chars_ff[3], chars_ff[4], chars_ff[5]} == KW_DELETE);
      end
      close_cls = word_kw ? CLS_KEYWORD : CLS_IDENT;
   end

   // next state and responses of the current request
   always_comb begin
      res0     = '0;
      res1     = '0;
      n_res    = 2'd0;
      mode_in  = mode_ff;
      chars_in = chars_ff;
      len_in   = len_ff;

      if (req_end_of_line) begin
         case (mode_ff)
            MODE_WORD: begin
               res0  = mk_close(close_cls);
               res1  = mk_close(CLS_END);
               n_res = 2'd2;
            end
            MODE_LIT: begin
               res0  = mk_close(CLS_LITERAL);
               res1  = mk_close(CLS_END);
               n_res = 2'd2;
            end
            default: begin
               res0  = mk_close(CLS_END);
               n_res = 2'd1;
            end
         endcase
         mode_in = MODE_IDLE;
         for (int i = 0; i < KEYWORD_CHARS; i++) chars_in[i] = '0;
         len_in = '0;
      end else begin
         case (mode_ff)
            MODE_WORD: begin
               if (is_alnum(req_char_code)) begin
                  res0  = mk_char(lc);
                  n_res = 2'd1;
                  for (int i = 0; i < KEYWORD_CHARS; i++) begin
                     if (len_ff == WORD_LEN_WIDTH'(i)) chars_in[i] = lc;
                  end
                  if (len_ff <= WORD_LEN_WIDTH'(KEYWORD_CHARS)) len_in = len_ff + 1'b1;
               end else begin
                  // close the word, then treat the character as from idle
                  res0 = mk_close(close_cls);
                  for (int i = 0; i < KEYWORD_CHARS; i++) chars_in[i] = '0;
                  len_in  = '0;
                  mode_in = MODE_IDLE;
                  if (is_space(req_char_code)) begin
                     n_res = 2'd1;
                  end else if (req_char_code == CHAR_QUOTE) begin
                     res1    = mk_char(CHAR_QUOTE);
                     n_res   = 2'd2;
                     mode_in = MODE_LIT;
                  end else begin
                     res1  = mk_close(CLS_INVALID);
                     n_res = 2'd2;
                  end
               end
            end
            MODE_LIT: begin
               if (req_char_code == CHAR_QUOTE) begin
                  res0    = mk_char(CHAR_QUOTE);
                  res1    = mk_close(CLS_LITERAL);
                  n_res   = 2'd2;
                  mode_in = MODE_IDLE;
               end else begin
                  res0  = mk_char(lc);
                  n_res = 2'd1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (is_space(req_char_code)) begin
                  n_res = 2'd0;
               end else if (is_alnum(req_char_code)) begin
                  mode_in = MODE_WORD;
                  for (int i = 0; i < KEYWORD_CHARS; i++) chars_in[i] = '0;
                  chars_in[0] = lc;
                  len_in      = WORD_LEN_WIDTH'(1);
                  res0        = mk_char(lc);
                  n_res       = 2'd1;
               end else if (req_char_code == CHAR_QUOTE) begin
                  mode_in = MODE_LIT;
                  res0    = mk_char(CHAR_QUOTE);
                  n_res   = 2'd1;
               end else begin
                  res0  = mk_close(CLS_INVALID);
                  n_res = 2'd1;
               end
            end
         endcase
      end

      // flag the last response of this request
      if (n_res == 2'd1) res0.last_of_run = 1'b1;
      if (n_res == 2'd2) res1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         for (int i = 0; i < KEYWORD_CHARS; i++) chars_ff[i] <= '0;
         len_ff  <= '0;
      end else if (req_take) begin
         mode_ff  <= mode_in;
         chars_ff <= chars_in;
         len_ff   <= len_in;
      end
   end

   // response queue storage: no reset needed on payload
   always_ff @(posedge clock) begin
      if (req_take && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
         if (n_res == 2'd2) queue_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_take) wr_ptr_ff <= wr_ptr_ff + RSP_PTR_WIDTH'(n_res);
         if (rsp_take) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (req_take ? RSP_CNT_WIDTH'(n_res) : '0)
                     - RSP_CNT_WIDTH'(rsp_take);
      end
   end

   assign rsp_valid       = (count_ff != '0);
   assign rsp_kind        = queue_ff[rd_ptr_ff].kind;
   assign rsp_value_char  = queue_ff[rd_ptr_ff].value_char;
   assign rsp_token_class = queue_ff[rd_ptr_ff].token_class;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;

endmodule

// ----- sv/cmdlex_checker.sv -----
// cmdlex_checker: port-level checks for command_lexer, bound to the top.
// Depends on cmdlex_pkg.
module cmdlex_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_value_char,
   input logic [2:0] rsp_token_class,
   input logic       rsp_last_of_run
);
   import cmdlex_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_value_char) && $stable(rsp_token_class) && $stable(rsp_last_of_run))
      else $error("response changed while stalled");

   a_char_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHAR |-> rsp_token_class == CLS_END)
      else $error("value character carries a class");

   a_close_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CLOSE |-> rsp_value_char == 8'd0)
      else $error("token close carries a character");

   // end of line always ends its run with an end token
   a_eol_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CLOSE && rsp_token_class == CLS_END |-> rsp_last_of_run)
      else $error("end token not last of run");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind command_lexer cmdlex_checker u_cmdlex_checker (.*);
